>>> rtl/lts_pkg.sv
// ----------------------------------------------------------------------------
// lts_pkg
// Types, character codes and limits shared by the line token splitter.
// ----------------------------------------------------------------------------
package lts_pkg;

  localparam int MAX_LINE_LENGTH   = 4096;
  localparam int MAX_BRACKET_DEPTH = 15;
  localparam int MAX_RES           = 3;

  localparam int CH_W    = 8;
  localparam int POS_W   = 12;
  localparam int BPOS_W  = $clog2(MAX_LINE_LENGTH + 1);
  localparam int TOK_W   = 16;
  localparam int DEPTH_W = $clog2(MAX_BRACKET_DEPTH + 1);
  localparam int CNT_W   = $clog2(MAX_RES + 1);
  localparam int CFG_W   = 16;
  localparam int CFG_A_W = 1;

  localparam logic [TOK_W-1:0] MAX_TOKENS_RESET = 16'hFFFF;

  typedef enum logic [CFG_A_W-1:0] {
    CFG_EQ_SPLIT   = 1'b0,
    CFG_MAX_TOKENS = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_END   = 2'd1,
    KIND_DONE  = 2'd2,
    KIND_ERROR = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    QUOTE_NONE   = 2'd0,
    QUOTE_DOUBLE = 2'd1,
    QUOTE_SINGLE = 2'd2,
    QUOTE_BACK   = 2'd3
  } quote_t;

  localparam logic [CH_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CH_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CH_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CH_W-1:0] CH_TILDE  = 8'h7E;
  localparam logic [CH_W-1:0] CH_DQUOTE = 8'h22;
  localparam logic [CH_W-1:0] CH_HASH   = 8'h23;
  localparam logic [CH_W-1:0] CH_SQUOTE = 8'h27;
  localparam logic [CH_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CH_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CH_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [CH_W-1:0] CH_EQUALS = 8'h3D;
  localparam logic [CH_W-1:0] CH_LBRACK = 8'h5B;
  localparam logic [CH_W-1:0] CH_RBRACK = 8'h5D;
  localparam logic [CH_W-1:0] CH_BQUOTE = 8'h60;
  localparam logic [CH_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [CH_W-1:0] CH_RBRACE = 8'h7D;

  typedef struct packed {
    kind_t             kind;
    logic [POS_W-1:0]  position;
    logic [TOK_W-1:0]  token_total;
    logic              last;
  } res_t;

  typedef res_t [MAX_RES-1:0] res_vec_t;

  function automatic logic is_ws(input logic [CH_W-1:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_pr(input logic [CH_W-1:0] c);
    return (c >= CH_SPACE) && (c <= CH_TILDE);
  endfunction

  function automatic logic is_open(input logic [CH_W-1:0] c);
    return (c == CH_LPAREN) || (c == CH_LBRACK) || (c == CH_LBRACE);
  endfunction

  function automatic logic is_close(input logic [CH_W-1:0] c);
    return (c == CH_RPAREN) || (c == CH_RBRACK) || (c == CH_RBRACE);
  endfunction

  function automatic quote_t quote_code(input logic [CH_W-1:0] c);
    quote_t q;
    q = QUOTE_NONE;
    if (c == CH_DQUOTE) begin
      q = QUOTE_DOUBLE;
    end else if (c == CH_SQUOTE) begin
      q = QUOTE_SINGLE;
    end else if (c == CH_BQUOTE) begin
      q = QUOTE_BACK;
    end
    return q;
  endfunction

endpackage

>>> rtl/lts_if.sv
// ----------------------------------------------------------------------------
// lts_in_if / lts_out_if
// Valid/ready channels for input bytes and for result transactions.
// ----------------------------------------------------------------------------
interface lts_in_if;
  logic                     valid;
  logic                     ready;
  logic [lts_pkg::CH_W-1:0] ch;
  logic                     line_start;

  modport source (output valid, output ch, output line_start, input ready);
  modport sink (input valid, input ch, input line_start, output ready);
endinterface

interface lts_out_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                kind;
  logic [lts_pkg::POS_W-1:0] position;
  logic [lts_pkg::TOK_W-1:0] token_total;
  logic                      last;

  modport source (output valid, output kind, output position, output token_total,
                  output last, input ready);
  modport sink (input valid, input kind, input position, input token_total,
                input last, output ready);
endinterface

>>> rtl/line_token_splitter.sv
// ----------------------------------------------------------------------------
// line_token_splitter
// Splits a byte stream of text lines into tokens and reports token start and
// end offsets, line completion and errors.
// ----------------------------------------------------------------------------
// Channel   Direction  Transaction
// in_if     sink       one byte of a line, with a line start flag
// out_if    source     one result: kind, position, token total, last flag
// cfg_*     write      split at equals flag (index 0), token limit (index 1)
//
// A byte is decoded in the cycle it is accepted and its zero to three results
// go to a three-entry result register that drains one per cycle while the
// output is ready. A byte giving at most one result is then taken every cycle;
// a byte giving more holds off the next byte until its last result is taken.
// Reset clears the line state and empties the result register.
// A stalled output holds back input whenever a result is waiting.
// ----------------------------------------------------------------------------
module line_token_splitter (
  input  logic                         clk,
  input  logic                         rst_n,
  lts_in_if.sink                       in_if,
  lts_out_if.source                    out_if,
  input  logic                         cfg_we,
  input  logic [lts_pkg::CFG_A_W-1:0]  cfg_addr,
  input  logic [lts_pkg::CFG_W-1:0]    cfg_wdata
);

  logic                               split_r;
  logic [lts_pkg::TOK_W-1:0]          max_tok_r;

  lts_pkg::quote_t                    quote_r, quote_nxt;
  logic [lts_pkg::DEPTH_W-1:0]        depth_r, depth_nxt;
  logic                               tok_open_r, tok_open_nxt;
  logic                               eq_hold_r, eq_hold_nxt;
  logic                               cur_empty_r, cur_empty_nxt;
  logic                               sep_seen_r, sep_seen_nxt;
  logic                               pend_r, pend_nxt;
  logic [lts_pkg::POS_W-1:0]          pend_pos_r, pend_pos_nxt;
  logic                               skip_r, skip_nxt;
  logic                               finished_r, finished_nxt;
  logic [lts_pkg::BPOS_W-1:0]         byte_pos_r, byte_pos_nxt;
  logic [lts_pkg::TOK_W-1:0]          tok_cnt_r, tok_cnt_nxt;

  lts_pkg::res_vec_t                  res_q_r;
  logic [lts_pkg::CNT_W-1:0]          cnt_r;
  lts_pkg::res_vec_t                  res_v;
  logic [lts_pkg::CNT_W-1:0]          res_n;

  logic                               in_acc;
  logic                               out_acc;
  logic [lts_pkg::CH_W-1:0]           c;
  logic [lts_pkg::BPOS_W-1:0]         pos;
  logic [lts_pkg::POS_W-1:0]          pos12;
  logic                               ok;
  logic                               go;

  function automatic void push(inout lts_pkg::res_vec_t r,
                               inout logic [lts_pkg::CNT_W-1:0] n,
                               input lts_pkg::kind_t k,
                               input logic [lts_pkg::POS_W-1:0] p,
                               input logic [lts_pkg::TOK_W-1:0] tc);
    if (n != lts_pkg::CNT_W'(lts_pkg::MAX_RES)) begin
      r[n[1:0]].kind        = k;
      r[n[1:0]].position    = p;
      r[n[1:0]].token_total = tc;
      r[n[1:0]].last        = 1'b0;
      n = n + 1'b1;
    end
  endfunction

  function automatic void add_start(inout lts_pkg::res_vec_t r,
                                    inout logic [lts_pkg::CNT_W-1:0] n,
                                    inout logic [lts_pkg::TOK_W-1:0] tc,
                                    inout logic fin,
                                    output logic good,
                                    input logic [lts_pkg::POS_W-1:0] p,
                                    input logic [lts_pkg::TOK_W-1:0] max_tc);
    if (tc >= max_tc) begin
      push(r, n, lts_pkg::KIND_ERROR, p, tc);
      fin  = 1'b1;
      good = 1'b0;
    end else begin
      tc   = tc + 1'b1;
      push(r, n, lts_pkg::KIND_START, p, tc);
      good = 1'b1;
    end
  endfunction

  assign in_acc  = in_if.valid & in_if.ready;
  assign out_acc = out_if.valid & out_if.ready;
  assign in_if.ready = (cnt_r == '0) || ((cnt_r == lts_pkg::CNT_W'(1)) && out_if.ready);
  assign c = in_if.ch;

  always_comb begin
    quote_nxt     = quote_r;
    depth_nxt     = depth_r;
    tok_open_nxt  = tok_open_r;
    eq_hold_nxt   = eq_hold_r;
    cur_empty_nxt = cur_empty_r;
    sep_seen_nxt  = sep_seen_r;
    pend_nxt      = pend_r;
    pend_pos_nxt  = pend_pos_r;
    skip_nxt      = skip_r;
    finished_nxt  = finished_r;
    byte_pos_nxt  = byte_pos_r;
    tok_cnt_nxt   = tok_cnt_r;
    res_v         = '0;
    res_n         = '0;
    ok            = 1'b1;
    go            = 1'b1;

    if (in_if.line_start) begin
      quote_nxt     = lts_pkg::QUOTE_NONE;
      depth_nxt     = '0;
      tok_open_nxt  = 1'b0;
      eq_hold_nxt   = 1'b0;
      cur_empty_nxt = 1'b1;
      sep_seen_nxt  = 1'b0;
      pend_nxt      = 1'b0;
      pend_pos_nxt  = '0;
      skip_nxt      = 1'b0;
      finished_nxt  = 1'b0;
      byte_pos_nxt  = '0;
      tok_cnt_nxt   = '0;
    end else if (finished_r) begin
      go = 1'b0;
    end

    pos   = byte_pos_nxt;
    pos12 = pos[lts_pkg::POS_W-1:0];

    if (go) begin
      if (pos >= lts_pkg::BPOS_W'(lts_pkg::MAX_LINE_LENGTH)) begin
        push(res_v, res_n, lts_pkg::KIND_ERROR, pos12, tok_cnt_nxt);
        finished_nxt = 1'b1;
      end else begin
        byte_pos_nxt = pos + 1'b1;
        if (skip_nxt) begin
          if (!tok_open_nxt) begin
            if (lts_pkg::is_ws(c)) begin
              ok = 1'b0;
            end else begin
              add_start(res_v, res_n, tok_cnt_nxt, finished_nxt, ok, pos12, max_tok_r);
              if (ok) begin
                tok_open_nxt = 1'b1;
              end
            end
          end
          if (ok && (c == lts_pkg::CH_NUL)) begin
            push(res_v, res_n, lts_pkg::KIND_END, pos12, tok_cnt_nxt);
            tok_open_nxt = 1'b0;
            push(res_v, res_n, lts_pkg::KIND_DONE, pos12, tok_cnt_nxt);
            finished_nxt = 1'b1;
          end
        end else begin
          if (pend_nxt) begin
            if (lts_pkg::is_ws(c)) begin
              go = 1'b0;
            end else begin
              pend_nxt = 1'b0;
              if ((c == lts_pkg::CH_EQUALS) && !split_r) begin
                eq_hold_nxt = 1'b1;
                go = 1'b0;
              end else begin
                push(res_v, res_n, lts_pkg::KIND_END, pend_pos_nxt, tok_cnt_nxt);
                tok_open_nxt = 1'b0;
              end
            end
          end
          if (go) begin
            if (quote_nxt != lts_pkg::QUOTE_NONE) begin
              if (c == lts_pkg::CH_NUL) begin
                push(res_v, res_n, lts_pkg::KIND_ERROR, pos12, tok_cnt_nxt);
                finished_nxt = 1'b1;
              end else if (lts_pkg::quote_code(c) == quote_nxt) begin
                quote_nxt = lts_pkg::QUOTE_NONE;
              end else if (!lts_pkg::is_ws(c) && !lts_pkg::is_pr(c)) begin
                push(res_v, res_n, lts_pkg::KIND_ERROR, pos12, tok_cnt_nxt);
                finished_nxt = 1'b1;
              end
            end else if (depth_nxt != '0) begin
              if (c == lts_pkg::CH_NUL) begin
                push(res_v, res_n, lts_pkg::KIND_ERROR, pos12, tok_cnt_nxt);
                finished_nxt = 1'b1;
              end else if (lts_pkg::is_open(c)) begin
                if (depth_nxt >= lts_pkg::DEPTH_W'(lts_pkg::MAX_BRACKET_DEPTH)) begin
                  push(res_v, res_n, lts_pkg::KIND_ERROR, pos12, tok_cnt_nxt);
                  finished_nxt = 1'b1;
                end else begin
                  depth_nxt = depth_nxt + 1'b1;
                end
              end else if (lts_pkg::is_close(c)) begin
                depth_nxt = depth_nxt - 1'b1;
              end else if (!lts_pkg::is_ws(c) && !lts_pkg::is_pr(c)) begin
                push(res_v, res_n, lts_pkg::KIND_ERROR, pos12, tok_cnt_nxt);
                finished_nxt = 1'b1;
              end
            end else if ((c == lts_pkg::CH_NUL) || (c == lts_pkg::CH_HASH)) begin
              if (sep_seen_nxt && cur_empty_nxt) begin
                add_start(res_v, res_n, tok_cnt_nxt, finished_nxt, ok, pos12, max_tok_r);
                if (ok) begin
                  push(res_v, res_n, lts_pkg::KIND_END, pos12, tok_cnt_nxt);
                end
              end else if (tok_open_nxt) begin
                push(res_v, res_n, lts_pkg::KIND_END, pos12, tok_cnt_nxt);
              end
              if (ok) begin
                tok_open_nxt = 1'b0;
                push(res_v, res_n, lts_pkg::KIND_DONE, pos12, tok_cnt_nxt);
                finished_nxt = 1'b1;
              end
            end else if (c == lts_pkg::CH_EQUALS) begin
              eq_hold_nxt = 1'b1;
              if (split_r) begin
                if (tok_open_nxt) begin
                  push(res_v, res_n, lts_pkg::KIND_END, pos12, tok_cnt_nxt);
                end
                tok_open_nxt = 1'b0;
                skip_nxt     = 1'b1;
              end
            end else if (c == lts_pkg::CH_COMMA) begin
              if (cur_empty_nxt) begin
                add_start(res_v, res_n, tok_cnt_nxt, finished_nxt, ok, pos12, max_tok_r);
                if (ok) begin
                  push(res_v, res_n, lts_pkg::KIND_END, pos12, tok_cnt_nxt);
                end
              end else if (tok_open_nxt) begin
                push(res_v, res_n, lts_pkg::KIND_END, pos12, tok_cnt_nxt);
              end
              if (ok) begin
                eq_hold_nxt   = 1'b0;
                tok_open_nxt  = 1'b0;
                cur_empty_nxt = 1'b1;
                sep_seen_nxt  = 1'b1;
              end
            end else if (lts_pkg::is_ws(c)) begin
              if (tok_open_nxt && !eq_hold_nxt) begin
                if (!split_r) begin
                  pend_nxt     = 1'b1;
                  pend_pos_nxt = pos12;
                end else begin
                  push(res_v, res_n, lts_pkg::KIND_END, pos12, tok_cnt_nxt);
                  tok_open_nxt = 1'b0;
                end
              end
            end else if (lts_pkg::is_pr(c)) begin
              if (!tok_open_nxt) begin
                tok_open_nxt = 1'b1;
                add_start(res_v, res_n, tok_cnt_nxt, finished_nxt, ok, pos12, max_tok_r);
              end
              if (ok) begin
                if (lts_pkg::quote_code(c) != lts_pkg::QUOTE_NONE) begin
                  quote_nxt = lts_pkg::quote_code(c);
                end else if (lts_pkg::is_open(c)) begin
                  depth_nxt = lts_pkg::DEPTH_W'(1);
                end
                cur_empty_nxt = 1'b0;
                eq_hold_nxt   = 1'b0;
              end
            end else begin
              push(res_v, res_n, lts_pkg::KIND_ERROR, pos12, tok_cnt_nxt);
              finished_nxt = 1'b1;
            end
          end
        end
      end
    end

    if (res_n != '0) begin
      res_v[res_n[1:0] - 2'd1].last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      split_r   <= 1'b0;
      max_tok_r <= lts_pkg::MAX_TOKENS_RESET;
    end else if (cfg_we) begin
      unique case (lts_pkg::cfg_idx_t'(cfg_addr))
        lts_pkg::CFG_EQ_SPLIT:   split_r   <= cfg_wdata[0];
        lts_pkg::CFG_MAX_TOKENS: max_tok_r <= cfg_wdata[lts_pkg::TOK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quote_r     <= lts_pkg::QUOTE_NONE;
      depth_r     <= '0;
      tok_open_r  <= 1'b0;
      eq_hold_r   <= 1'b0;
      cur_empty_r <= 1'b1;
      sep_seen_r  <= 1'b0;
      pend_r      <= 1'b0;
      pend_pos_r  <= '0;
      skip_r      <= 1'b0;
      finished_r  <= 1'b0;
      byte_pos_r  <= '0;
      tok_cnt_r   <= '0;
    end else if (in_acc) begin
      quote_r     <= quote_nxt;
      depth_r     <= depth_nxt;
      tok_open_r  <= tok_open_nxt;
      eq_hold_r   <= eq_hold_nxt;
      cur_empty_r <= cur_empty_nxt;
      sep_seen_r  <= sep_seen_nxt;
      pend_r      <= pend_nxt;
      pend_pos_r  <= pend_pos_nxt;
      skip_r      <= skip_nxt;
      finished_r  <= finished_nxt;
      byte_pos_r  <= byte_pos_nxt;
      tok_cnt_r   <= tok_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (in_acc) begin
      cnt_r <= res_n;
    end else if (out_acc) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_q_r <= res_v;
    end else if (out_acc) begin
      res_q_r <= {lts_pkg::res_t'('0), res_q_r[lts_pkg::MAX_RES-1:1]};
    end
  end

  assign out_if.valid       = (cnt_r != '0);
  assign out_if.kind        = res_q_r[0].kind;
  assign out_if.position    = res_q_r[0].position;
  assign out_if.token_total = res_q_r[0].token_total;
  assign out_if.last        = res_q_r[0].last;

endmodule

>>> verif/lts_check_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lts_check_pkg
// Expected-result tracking for the line token splitter testbench. A byte-level
// parser mirrors the token rules and queues the start, end, line-done and
// error results that each accepted byte should produce. Results coming out of
// the block are compared against that queue in order.
// ----------------------------------------------------------------------------
package lts_check_pkg;
  import lts_pkg::*;

  class token_event_checker;
    bit          split_eq;
    int unsigned max_tok;
    quote_t      quote_kind;
    int unsigned depth;
    bit          tok_open;
    bit          eq_hold;
    bit          empty_tok;
    bit          sep_seen;
    bit          pend_end;
    bit          after_split;
    bit          finished;
    int unsigned pend_pos;
    int unsigned byte_pos;
    int unsigned tok_count;
    res_t        step_events[$];
    res_t        expected_events[$];
    int unsigned mismatches;

    function new();
      split_eq   = 1'b0;
      max_tok    = 32'(MAX_TOKENS_RESET);
      mismatches = 0;
      clear_line();
    endfunction

    function void clear_line();
      quote_kind  = QUOTE_NONE;
      depth       = 0;
      tok_open    = 1'b0;
      eq_hold     = 1'b0;
      empty_tok   = 1'b1;
      sep_seen    = 1'b0;
      pend_end    = 1'b0;
      pend_pos    = 0;
      after_split = 1'b0;
      finished    = 1'b0;
      byte_pos    = 0;
      tok_count   = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_EQ_SPLIT:   split_eq = val[0];
        CFG_MAX_TOKENS: max_tok = 32'(val);
        default: ;
      endcase
    endfunction

    function bit blank(logic [CH_W-1:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function bit visible(logic [CH_W-1:0] c);
      return (c >= CH_SPACE) && (c <= CH_TILDE);
    endfunction

    function bit opener(logic [CH_W-1:0] c);
      return (c == CH_LPAREN) || (c == CH_LBRACK) || (c == CH_LBRACE);
    endfunction

    function bit closer(logic [CH_W-1:0] c);
      return (c == CH_RPAREN) || (c == CH_RBRACK) || (c == CH_RBRACE);
    endfunction

    function quote_t quote_of(logic [CH_W-1:0] c);
      case (c)
        CH_DQUOTE: return QUOTE_DOUBLE;
        CH_SQUOTE: return QUOTE_SINGLE;
        CH_BQUOTE: return QUOTE_BACK;
        default:   return QUOTE_NONE;
      endcase
    endfunction

    function void emit(kind_t kind, int unsigned pos);
      res_t r;
      if (step_events.size() >= MAX_RES) return;
      r.kind        = kind;
      r.position    = pos[POS_W-1:0];
      r.token_total = tok_count[TOK_W-1:0];
      r.last        = 1'b0;
      step_events.push_back(r);
    endfunction

    function void fail(int unsigned pos);
      emit(KIND_ERROR, pos);
      finished = 1'b1;
    endfunction

    function bit add_start(int unsigned pos);
      if (tok_count >= max_tok) begin
        fail(pos);
        return 1'b0;
      end
      tok_count++;
      emit(KIND_START, pos);
      return 1'b1;
    endfunction

    function void end_line(int unsigned pos);
      emit(KIND_DONE, pos);
      finished = 1'b1;
    endfunction

    function void take_byte(logic [CH_W-1:0] c, int unsigned pos);
      // Once the line has been split at '=', the rest is one token up to NUL.
      if (after_split) begin
        if (!tok_open) begin
          if (blank(c)) return;
          if (!add_start(pos)) return;
          tok_open = 1'b1;
        end
        if (c == CH_NUL) begin
          emit(KIND_END, pos);
          tok_open = 1'b0;
          end_line(pos);
        end
        return;
      end
      // A space-terminated token stays open until a byte other than '=' shows up.
      if (pend_end) begin
        if (blank(c)) return;
        pend_end = 1'b0;
        if ((c == CH_EQUALS) && !split_eq) begin
          eq_hold = 1'b1;
          return;
        end
        emit(KIND_END, pend_pos);
        tok_open = 1'b0;
      end
      if (quote_kind != QUOTE_NONE) begin
        if (c == CH_NUL) begin
          fail(pos);
        end else if (quote_of(c) == quote_kind) begin
          quote_kind = QUOTE_NONE;
        end else if (!blank(c) && !visible(c)) begin
          fail(pos);
        end
      end else if (depth > 0) begin
        if (c == CH_NUL) begin
          fail(pos);
        end else if (opener(c)) begin
          if (depth >= MAX_BRACKET_DEPTH) begin
            fail(pos);
          end else begin
            depth++;
          end
        end else if (closer(c)) begin
          depth--;
        end else if (!blank(c) && !visible(c)) begin
          fail(pos);
        end
      end else if ((c == CH_NUL) || (c == CH_HASH)) begin
        if (sep_seen && empty_tok) begin
          if (!add_start(pos)) return;
          emit(KIND_END, pos);
        end else if (tok_open) begin
          emit(KIND_END, pos);
        end
        tok_open = 1'b0;
        end_line(pos);
      end else if (c == CH_EQUALS) begin
        eq_hold = 1'b1;
        if (split_eq) begin
          if (tok_open) emit(KIND_END, pos);
          tok_open    = 1'b0;
          after_split = 1'b1;
        end
      end else if (c == CH_COMMA) begin
        if (empty_tok) begin
          if (!add_start(pos)) return;
          emit(KIND_END, pos);
        end else if (tok_open) begin
          emit(KIND_END, pos);
        end
        eq_hold   = 1'b0;
        tok_open  = 1'b0;
        empty_tok = 1'b1;
        sep_seen  = 1'b1;
      end else if (blank(c)) begin
        if (tok_open && !eq_hold) begin
          if (!split_eq) begin
            pend_end = 1'b1;
            pend_pos = pos;
          end else begin
            emit(KIND_END, pos);
            tok_open = 1'b0;
          end
        end
      end else if (visible(c)) begin
        if (!tok_open) begin
          tok_open = 1'b1;
          if (!add_start(pos)) return;
        end
        if (quote_of(c) != QUOTE_NONE) begin
          quote_kind = quote_of(c);
        end else if (opener(c)) begin
          depth = 1;
        end
        empty_tok = 1'b0;
        eq_hold   = 1'b0;
      end else begin
        fail(pos);
      end
    endfunction

    // Returns 1 when the byte is dropped because the line has already ended.
    function bit note_byte(logic [CH_W-1:0] c, logic fresh);
      int unsigned pos;
      res_t        r;
      step_events.delete();
      if (fresh) begin
        clear_line();
      end else if (finished) begin
        return 1'b1;
      end
      pos = byte_pos;
      if (pos >= MAX_LINE_LENGTH) begin
        fail(pos);
      end else begin
        byte_pos = pos + 1;
        take_byte(c, pos);
      end
      if (step_events.size() > 0) begin
        r      = step_events.pop_back();
        r.last = 1'b1;
        step_events.push_back(r);
      end
      foreach (step_events[i]) expected_events.push_back(step_events[i]);
      return 1'b0;
    endfunction

    function void check_event(res_t got);
      res_t want;
      if (expected_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: kind %0d pos %0d total %0d last %0d",
                   got.kind, got.position, got.token_total, got.last);
        end
        return;
      end
      want = expected_events.pop_front();
      if ((got.kind !== want.kind) || (got.position !== want.position) ||
          (got.token_total !== want.token_total) || (got.last !== want.last)) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result differs: expected kind %0d pos %0d total %0d last %0d",
                   want.kind, want.position, want.token_total, want.last);
          $display("                actual   kind %0d pos %0d total %0d last %0d",
                   got.kind, got.position, got.token_total, got.last);
        end
      end
    endfunction

    function void flush_check();
      if (expected_events.size() != 0) begin
        mismatches++;
        $display("%0d expected results never arrived", expected_events.size());
      end
    endfunction
  endclass

endpackage

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the line token splitter. Short directed lines cover token
// separators, empty tokens, quotes, brackets, splitting at equals, token limits
// and bracket overflow; random lines then run under several register settings
// with random idle cycles on both channels, save one phase without them on the input and one on the output.
// ----------------------------------------------------------------------------
module tb_top;
  import lts_pkg::*;
  import lts_check_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int PHASES         = 6;
  localparam int PHASE_ITEMS    = 25;

  logic             clk   = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we;
  logic [CFG_A_W-1:0] cfg_addr;
  logic [CFG_W-1:0] cfg_wdata;

  lts_in_if  in_if ();
  lts_out_if out_if ();

  token_event_checker board;
  bit                 in_idle_on  = 1'b1;
  bit                 out_idle_on = 1'b1;
  int unsigned        live_items;
  int unsigned        idle_cycles;
  logic [CH_W-1:0]    line_q[$];

  line_token_splitter i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("line_token_splitter: mismatch");
      $finish;
    end
  end

  initial begin : result_sink
    int   gap;
    res_t got;
    out_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      gap = out_idle_on ? int'($urandom_range(0, 7)) : 0;
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!((out_if.valid === 1'b1) && (out_if.ready === 1'b1)));
      got.kind        = kind_t'(out_if.kind);
      got.position    = out_if.position;
      got.token_total = out_if.token_total;
      got.last        = out_if.last;
      board.check_event(got);
    end
  end

  task automatic send_byte(input logic [CH_W-1:0] c, input logic fresh);
    int gap;
    gap = in_idle_on ? int'($urandom_range(0, 7)) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.ch         <= c;
    in_if.line_start <= fresh;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    if (!board.note_byte(c, fresh)) live_items++;
  endtask

  task automatic send_text(input string s, input logic fresh);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], fresh && (i == 0));
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (board.expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(input bit split, input logic [CFG_W-1:0] max_tok);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_EQ_SPLIT;
    cfg_wdata <= {{(CFG_W-1){1'b0}}, split};
    @(posedge clk);
    board.set_reg(CFG_EQ_SPLIT, {{(CFG_W-1){1'b0}}, split});
    cfg_addr  <= CFG_MAX_TOKENS;
    cfg_wdata <= max_tok;
    @(posedge clk);
    board.set_reg(CFG_MAX_TOKENS, max_tok);
    cfg_we    <= 1'b0;
  endtask

  task automatic make_line();
    logic [CH_W-1:0] b;
    logic [CH_W-1:0] q;
    int              d;
    line_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 8)) begin
        b = CH_W'($urandom_range(0, 255));
        line_q.push_back(b);
      end
      return;
    end
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          repeat ($urandom_range(1, 4)) begin
            b = ($urandom_range(0, 3) == 0) ? CH_W'($urandom_range(48, 57)) :
                                              CH_W'($urandom_range(97, 122));
            line_q.push_back(b);
          end
        end
        3: begin
          repeat ($urandom_range(1, 3)) begin
            b = ($urandom_range(0, 2) == 0) ? CH_W'($urandom_range(CH_TAB, CH_CR)) : CH_SPACE;
            line_q.push_back(b);
          end
        end
        4: begin
          line_q.push_back(CH_COMMA);
          if ($urandom_range(0, 1) == 0) line_q.push_back(CH_SPACE);
        end
        5: begin
          if ($urandom_range(0, 1) == 0) line_q.push_back(CH_SPACE);
          line_q.push_back(CH_EQUALS);
          if ($urandom_range(0, 1) == 0) line_q.push_back(CH_SPACE);
        end
        6: begin
          case ($urandom_range(0, 2))
            0:       q = CH_DQUOTE;
            1:       q = CH_SQUOTE;
            default: q = CH_BQUOTE;
          endcase
          line_q.push_back(q);
          repeat ($urandom_range(0, 4)) begin
            do b = CH_W'($urandom_range(CH_SPACE, CH_TILDE)); while (b == q);
            line_q.push_back(b);
          end
          if ($urandom_range(0, 7) != 0) line_q.push_back(q);
        end
        7: begin
          d = ($urandom_range(0, 9) == 0) ? int'($urandom_range(14, 17)) :
                                            int'($urandom_range(1, 3));
          repeat (d) begin
            case ($urandom_range(0, 2))
              0:       line_q.push_back(CH_LPAREN);
              1:       line_q.push_back(CH_LBRACK);
              default: line_q.push_back(CH_LBRACE);
            endcase
          end
          repeat ($urandom_range(0, 3)) begin
            b = CH_W'($urandom_range(CH_SPACE, CH_TILDE));
            line_q.push_back(b);
          end
          if ($urandom_range(0, 7) != 0) begin
            repeat (d) begin
              case ($urandom_range(0, 2))
                0:       line_q.push_back(CH_RPAREN);
                1:       line_q.push_back(CH_RBRACK);
                default: line_q.push_back(CH_RBRACE);
              endcase
            end
          end
        end
        8: begin
          b = CH_W'($urandom_range(0, 255));
          line_q.push_back(b);
        end
        default: begin
          b = CH_W'($urandom_range(33, 126));
          line_q.push_back(b);
        end
      endcase
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: line_q.push_back(CH_NUL);
      6, 7:             line_q.push_back(CH_HASH);
      8: ;
      default: begin
        line_q.push_back(CH_NUL);
        repeat ($urandom_range(1, 3)) begin
          b = CH_W'($urandom_range(0, 255));
          line_q.push_back(b);
        end
      end
    endcase
  endtask

  initial begin : stimulus
    bit              split;
    logic [CFG_W-1:0] max_tok;
    logic            fresh;
    board = new();
    cfg_we           <= 1'b0;
    cfg_addr         <= CFG_EQ_SPLIT;
    cfg_wdata        <= '0;
    in_if.valid      <= 1'b0;
    in_if.ch         <= CH_NUL;
    in_if.line_start <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // The first line after reset carries no line start flag.
    send_text("a,,b = c #", 1'b0);
    send_text("'(", 1'b1);
    send_byte(CH_NUL, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_text("x", 1'b0);
    send_text("(a", 1'b1);
    send_byte(CH_NUL, 1'b0);
    send_text("x,", 1'b1);
    send_byte(CH_NUL, 1'b0);
    send_text(")", 1'b1);
    send_byte(CH_NUL, 1'b0);

    drain_results();
    apply_settings(1'b1, MAX_TOKENS_RESET);
    send_text("k = v #x", 1'b1);
    send_byte(CH_NUL, 1'b0);

    drain_results();
    apply_settings(1'b0, 16'd1);
    send_text("a b", 1'b1);

    drain_results();
    apply_settings(1'b0, MAX_TOKENS_RESET);
    for (int i = 0; i <= MAX_BRACKET_DEPTH; i++) send_byte(CH_LPAREN, i == 0);
    send_byte(CH_NUL, 1'b0);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      case (ph)
        0: begin
          split   = 1'b0;
          max_tok = MAX_TOKENS_RESET;
        end
        1: begin
          split   = 1'b1;
          max_tok = MAX_TOKENS_RESET;
        end
        2: begin
          split   = 1'b0;
          max_tok = 16'd1;
        end
        3: begin
          split   = 1'b1;
          max_tok = 16'd2;
        end
        4: begin
          split   = 1'($urandom_range(0, 1));
          max_tok = CFG_W'($urandom_range(1, 6));
        end
        default: begin
          split   = 1'($urandom_range(0, 1));
          max_tok = CFG_W'($urandom_range(1, 65535));
        end
      endcase
      apply_settings(split, max_tok);
      in_idle_on  = (ph != 2);
      out_idle_on = (ph != 4);
      live_items  = 0;
      while (live_items < PHASE_ITEMS) begin
        make_line();
        fresh = ($urandom_range(0, 19) != 0);
        foreach (line_q[i]) send_byte(line_q[i], fresh && (i == 0));
      end
    end

    drain_results();
    board.flush_check();
    if (board.mismatches == 0) begin
      $display("line_token_splitter: match");
    end else begin
      $display("line_token_splitter: mismatch");
    end
    $finish;
  end

endmodule

>>> line_token_splitter.f
rtl/lts_pkg.sv
rtl/lts_if.sv
rtl/line_token_splitter.sv
verif/lts_check_pkg.sv
verif/tb_top.sv
